FILE: rtl/trs_pkg.sv
// Shared types, constants and codes of the tracker row/order sequencer.
package trs_pkg;

	localparam int ORDER_DEPTH_DEF   = 256;
	localparam int PATTERN_COUNT_DEF = 256;

	localparam logic [7:0] SPEED_SPLIT  = 8'h20;
	localparam logic [3:0] NIBBLE_MASK  = 4'hF;
	localparam logic [3:0] DECIMAL_BASE = 4'd10;
	localparam logic [8:0] MAX_ROWS     = 9'd256;
	localparam logic [7:0] FX_BREAK     = 8'h0D;
	localparam logic [7:0] FX_EXTENDED  = 8'h0E;
	localparam logic [7:0] FX_SPEED     = 8'h0F;
	localparam logic [3:0] EXT_LOOP     = 4'd6;
	localparam logic [31:0] TICK_NUMER  = 32'd2500 << 16;
	localparam logic [31:0] TICK_RESET  = 32'd1310720;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_EFFECT = 3'd1,
		OP_TIME   = 3'd2,
		OP_ORDER  = 3'd3,
		OP_LENGTH = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CFG_ORDER_LENGTH = 3'd0,
		CFG_RESTART      = 3'd1,
		CFG_LOOP_PATTERN = 3'd2,
		CFG_INIT_TEMPO   = 3'd3,
		CFG_INIT_BPM     = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_ROW,
		ST_PATT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  position;
		logic [7:0]  start_row;
		logic        song_loops;
		logic [7:0]  effect_code;
		logic [7:0]  fx_param;
		logic        first_cell;
		logic [15:0] elapsed_ms;
		logic [8:0]  table_value;
	} req_t;

	typedef struct packed {
		logic [7:0] order_position;
		logic [7:0] current_row;
		logic [7:0] current_pattern;
		logic       row_started;
		logic       tick_started;
		logic       finished;
		logic       is_playing;
		logic [4:0] tempo_now;
		logic [7:0] bpm_now;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

FILE: rtl/trs_if.sv
// Valid/ready channel and configuration write channel interfaces.
interface trs_req_if import trs_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trs_rsp_if import trs_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trs_cfg_if ();
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [8:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/trs_div.sv
// Restoring serial divider for the tick length, one quotient bit a cycle.
module trs_div import trs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl,
	input  logic [7:0]  divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] quo_q;
	logic [7:0]  rem_q;
	logic [5:0]  cnt_q;
	logic [8:0]  trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= TICK_NUMER;
			rem_q <= '0;
		end else if (cnt_q != 6'd0) begin
			if (!trial[8]) begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[6:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != 6'd0);
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) ctl.start |=> busy)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> cnt_q <= 6'd32)
		else $error("divider count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(cnt_q) == 6'd1) |-> !busy)
		else $error("divider did not stop");
endmodule

FILE: rtl/trs_tables.sv
// Order table and pattern length table memories with registered reads.
module trs_tables import trs_pkg::*; #(
	parameter int ORDER_DEPTH   = ORDER_DEPTH_DEF,
	parameter int PATTERN_COUNT = PATTERN_COUNT_DEF
) (
	input  logic       clk,
	input  logic       ord_we,
	input  logic       len_we,
	input  logic [7:0] waddr,
	input  logic [8:0] wdata,
	input  logic [7:0] ord_raddr,
	input  logic [7:0] len_raddr,
	output logic [7:0] ord_rdata,
	output logic [8:0] len_rdata
);
	localparam int OAW = $clog2(ORDER_DEPTH);
	localparam int LAW = $clog2(PATTERN_COUNT);

	logic [7:0] ord_mem [ORDER_DEPTH];
	logic [8:0] len_mem [PATTERN_COUNT];
	logic       ord_ok_q;
	logic       len_ok_q;
	logic [7:0] ord_q;
	logic [8:0] len_q;

	always_ff @(posedge clk) begin
		if (ord_we && 32'(waddr) < ORDER_DEPTH) begin
			ord_mem[waddr[OAW-1:0]] <= wdata[7:0];
		end
		ord_q    <= ord_mem[ord_raddr[OAW-1:0]];
		ord_ok_q <= 32'(ord_raddr) < ORDER_DEPTH;
	end

	always_ff @(posedge clk) begin
		if (len_we && 32'(waddr) < PATTERN_COUNT) begin
			len_mem[waddr[LAW-1:0]] <= wdata;
		end
		len_q    <= len_mem[len_raddr[LAW-1:0]];
		len_ok_q <= 32'(len_raddr) < PATTERN_COUNT;
	end

	assign ord_rdata = ord_ok_q ? ord_q : 8'd0;
	assign len_rdata = len_ok_q ? len_q : 9'd0;
endmodule

FILE: rtl/tracker_row_order_sequencer_top.sv
// Top level of the tracker row/order sequencer: sequencer, state and output register.
//  channel | dir | handshake      | payload
//  req     | in  | valid/ready    | operation, position, start_row, ... table_value
//  rsp     | out | valid/ready    | order_position, current_row, ... bpm_now
//  cfg     | in  | valid/ready    | index (3), wdata (9)
// A start, or a speed effect that sets bpm while playing, runs the serial divider
// before its result is presented.
// A time item while playing runs the steps sum, tick and row, pattern address, pattern read.
// Other items skip these. The shared divider and the single table read port set these sequences.
// arst_n clears all control state; table contents are undefined until written.
// req.ready is low while an item is in work or its result waits in rsp.
module tracker_row_order_sequencer_top import trs_pkg::*; #(
	parameter int ORDER_DEPTH   = ORDER_DEPTH_DEF,
	parameter int PATTERN_COUNT = PATTERN_COUNT_DEF
) (
	input logic    clk,
	input logic    arst_n,
	trs_req_if.sink   req,
	trs_rsp_if.source rsp,
	trs_cfg_if.sink   cfg
);
	state_t state_q, state_d;
	req_t   req_q;

	logic [8:0] order_length_q;
	logic [7:0] restart_q;
	logic       loop_pat_q;
	logic [4:0] init_tempo_q;
	logic [7:0] init_bpm_q;

	logic [7:0]  pos_q, row_q, pattern_q;
	logic [31:0] acc_q, tick_len_q;
	logic [4:0]  ticks_q;
	logic        running_q, wrap_q, fresh_q;
	logic [7:0]  loop_row_q;
	logic [3:0]  loop_rem_q;
	logic        loop_pend_q, break_pend_q;
	logic [7:0]  break_row_q;
	logic [4:0]  tempo_q;
	logic [7:0]  bpm_q;
	logic        row_st_q, tick_st_q, fin_q;
	logic        adv_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	div_ctl_t    div_ctl;
	logic        div_busy;
	logic [31:0] div_quo;
	logic [7:0]  div_den;
	logic [7:0]  ord_rd;
	logic [8:0]  len_rd;
	logic [7:0]  rd_addr;

	logic        accept;
	logic [31:0] add_w, sum_w;
	logic        ovf_w;
	logic [4:0]  tick_inc;
	logic        bpm_set;
	logic [8:0]  len_clip;
	logic        last_row;
	logic        has_next;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign cfg.ready = 1'b1;
	assign has_next  = {1'b0, pos_q} + 9'd1 < order_length_q;
	assign len_clip  = (len_rd > MAX_ROWS) ? MAX_ROWS : len_rd;
	assign last_row  = {1'b0, row_q} + 9'd1 >= len_clip;
	assign add_w     = {req_q.elapsed_ms, 16'd0};
	assign {ovf_w, sum_w} = {1'b0, acc_q} + {1'b0, add_w};
	assign tick_inc  = ticks_q + 5'd1;
	assign bpm_set   = req_q.effect_code == FX_SPEED && req_q.fx_param >= SPEED_SPLIT;
	assign div_den   = (req_q.operation == OP_START) ? init_bpm_q : req_q.fx_param;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_length_q <= 9'd1;
			restart_q      <= '0;
			loop_pat_q     <= 1'b0;
			init_tempo_q   <= 5'd6;
			init_bpm_q     <= 8'd125;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ORDER_LENGTH: order_length_q <= cfg.wdata;
				CFG_RESTART:      restart_q      <= cfg.wdata[7:0];
				CFG_LOOP_PATTERN: loop_pat_q     <= cfg.wdata[0];
				CFG_INIT_TEMPO:   init_tempo_q   <= cfg.wdata[4:0];
				CFG_INIT_BPM:     init_bpm_q     <= cfg.wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				priority if (req_q.operation == OP_START) begin
					state_d = ST_READ;
				end else if (req_q.operation == OP_EFFECT && running_q && bpm_set) begin
					state_d = ST_READ;
				end else if (req_q.operation == OP_TIME && running_q) begin
					state_d = ST_ROW;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				if (!div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_ROW:  state_d = ST_PATT;
			ST_PATT: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_ctl.start = (state_q == ST_DIV) && (state_d == ST_READ);
		div_ctl.busy  = div_busy;
		rd_addr       = pos_q;
		if (state_q == ST_IDLE) begin
			rd_addr = req.data.position;
		end
		if (state_q == ST_DIV) begin
			rd_addr = pattern_q;
		end
	end

	trs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.divisor  (div_den == 8'd0 ? 8'd1 : div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	trs_tables #(
		.ORDER_DEPTH   (ORDER_DEPTH),
		.PATTERN_COUNT (PATTERN_COUNT)
	) u_tables (
		.clk       (clk),
		.ord_we    (accept && req.data.operation == OP_ORDER),
		.len_we    (accept && req.data.operation == OP_LENGTH),
		.waddr     (req.data.position),
		.wdata     (req.data.table_value),
		.ord_raddr (rd_addr),
		.len_raddr (rd_addr),
		.ord_rdata (ord_rd),
		.len_rdata (len_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			row_q        <= '0;
			pattern_q    <= '0;
			acc_q        <= '0;
			tick_len_q   <= TICK_RESET;
			ticks_q      <= '0;
			running_q    <= 1'b0;
			wrap_q       <= 1'b1;
			fresh_q      <= 1'b0;
			loop_row_q   <= '0;
			loop_rem_q   <= '0;
			loop_pend_q  <= 1'b0;
			break_pend_q <= 1'b0;
			break_row_q  <= '0;
			tempo_q      <= 5'd6;
			bpm_q        <= 8'd125;
			row_st_q     <= 1'b0;
			tick_st_q    <= 1'b0;
			fin_q        <= 1'b0;
			adv_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_st_q  <= 1'b0;
						tick_st_q <= 1'b0;
						fin_q     <= 1'b0;
						adv_q     <= 1'b0;
					end
				end
				ST_DIV: begin
					unique case (req_q.operation)
						OP_START: begin
							pos_q        <= req_q.position;
							row_q        <= req_q.start_row;
							pattern_q    <= ord_rd;
							wrap_q       <= req_q.song_loops;
							acc_q        <= '0;
							ticks_q      <= '0;
							fresh_q      <= 1'b1;
							loop_row_q   <= '0;
							loop_rem_q   <= '0;
							loop_pend_q  <= 1'b0;
							break_pend_q <= 1'b0;
							break_row_q  <= '0;
							tempo_q      <= (init_tempo_q == 5'd0) ? 5'd1 : init_tempo_q;
							bpm_q        <= init_bpm_q;
							running_q    <= 1'b1;
						end
						OP_EFFECT: begin
							if (running_q) begin
								if (req_q.effect_code == FX_EXTENDED &&
										req_q.fx_param[7:4] == EXT_LOOP) begin
									if (req_q.first_cell) begin
										break_pend_q <= 1'b0;
									end
									if ((req_q.fx_param[3:0] & NIBBLE_MASK) == 4'd0) begin
										loop_row_q <= row_q;
										if (req_q.first_cell) begin
											loop_pend_q <= 1'b0;
										end
									end else if (loop_rem_q != 4'd0) begin
										loop_rem_q <= loop_rem_q - 4'd1;
										if (loop_rem_q == 4'd1) begin
											loop_row_q  <= '0;
											if (req_q.first_cell) begin
												loop_pend_q <= 1'b0;
											end
										end else begin
											loop_pend_q <= 1'b1;
										end
									end else begin
										loop_rem_q  <= req_q.fx_param[3:0];
										loop_pend_q <= 1'b1;
									end
								end else begin
									if (req_q.first_cell) begin
										loop_pend_q <= 1'b0;
										if (req_q.effect_code != FX_BREAK) begin
											break_pend_q <= 1'b0;
										end
									end
									if (req_q.effect_code == FX_BREAK) begin
										break_pend_q <= 1'b1;
										break_row_q  <= 8'({4'd0, req_q.fx_param[7:4]}
											* {4'd0, DECIMAL_BASE})
											+ {4'd0, req_q.fx_param[3:0]};
									end else if (req_q.effect_code == FX_SPEED) begin
										if (req_q.fx_param < SPEED_SPLIT) begin
											tempo_q <= (req_q.fx_param == 8'd0) ? 5'd1
												: req_q.fx_param[4:0];
										end else begin
											bpm_q <= req_q.fx_param;
										end
									end
								end
							end
						end
						OP_TIME: begin
							if (running_q) begin
								if (fresh_q) begin
									fresh_q   <= 1'b0;
									row_st_q  <= 1'b1;
									tick_st_q <= 1'b1;
								end
								acc_q <= ovf_w ? 32'hFFFF_FFFF : sum_w;
							end
						end
						default: ;
					endcase
				end
				ST_READ: begin
					if (!div_busy) begin
						tick_len_q <= div_quo;
					end
				end
				ST_ROW: begin
					if (acc_q >= tick_len_q) begin
						tick_st_q <= 1'b1;
						acc_q     <= acc_q - tick_len_q;
						if (tick_inc >= tempo_q) begin
							ticks_q      <= '0;
							loop_pend_q  <= 1'b0;
							break_pend_q <= 1'b0;
							priority if (loop_pend_q) begin
								row_q    <= loop_row_q;
								row_st_q <= 1'b1;
								adv_q    <= 1'b1;
							end else if (break_pend_q) begin
								row_q    <= break_row_q;
								pos_q    <= has_next ? pos_q + 8'd1 : restart_q;
								row_st_q <= 1'b1;
								adv_q    <= 1'b1;
							end else if (last_row) begin
								if (loop_pat_q) begin
									row_q    <= '0;
									row_st_q <= 1'b1;
									adv_q    <= 1'b1;
								end else if (has_next) begin
									pos_q    <= pos_q + 8'd1;
									row_q    <= '0;
									row_st_q <= 1'b1;
									adv_q    <= 1'b1;
								end else if (wrap_q) begin
									pos_q    <= restart_q;
									row_q    <= '0;
									row_st_q <= 1'b1;
									adv_q    <= 1'b1;
								end else begin
									running_q <= 1'b0;
									fin_q     <= 1'b1;
									row_st_q  <= 1'b0;
								end
							end else begin
								row_q    <= row_q + 8'd1;
								row_st_q <= 1'b1;
								adv_q    <= 1'b1;
							end
						end else begin
							ticks_q <= tick_inc;
						end
					end
				end
				ST_PATT: ;
				ST_DONE: begin
					rsp_valid_q <= 1'b1;
					if (adv_q) begin
						pattern_q <= ord_rd;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.data;
		end
	end

	always_comb begin
		rsp_q.order_position  = pos_q;
		rsp_q.current_row     = row_q;
		rsp_q.current_pattern = pattern_q;
		rsp_q.row_started     = row_st_q;
		rsp_q.tick_started    = tick_st_q;
		rsp_q.finished        = fin_q;
		rsp_q.is_playing      = running_q;
		rsp_q.tempo_now       = tempo_q;
		rsp_q.bpm_now         = bpm_q;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n) rsp_valid_q |-> !req.ready)
		else $error("accepting while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n) fin_q |-> !running_q)
		else $error("finished while still playing");
	assert property (@(posedge clk) disable iff (!arst_n) running_q |-> tempo_q != 5'd0)
		else $error("zero tempo while playing");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> rsp_valid_q)
		else $error("result not presented");
endmodule

FILE: verif/tb_tracker_row_order_sequencer_top.sv
// Testbench of the tracker row/order sequencer: directed and random requests checked against a local predictor.
`timescale 1ns / 100ps

module tb_tracker_row_order_sequencer_top;
	import trs_pkg::*;

	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;
	localparam logic [3:0] LOOP_SET   = 4'd0;
	localparam int STALL_LIMIT  = 20000;
	localparam int ITEMS_PER_PHASE = 25;
	localparam int USED_PATTERNS = 16;

	class song_scoreboard;
		bit [7:0]  order_tab [256];
		bit [8:0]  rows_tab [256];
		bit [7:0]  pos, row, pattern;
		bit [31:0] acc, tick_len;
		bit [4:0]  ticks;
		bit        running, wrap, fresh;
		bit [7:0]  loop_row;
		bit [3:0]  loop_left;
		bit        loop_jump, brk;
		bit [7:0]  brk_row;
		bit [4:0]  tempo;
		bit [7:0]  bpm;
		bit [8:0]  ord_len;
		bit [7:0]  restart;
		bit        loop_pat;
		bit [4:0]  init_tempo;
		bit [7:0]  init_bpm;
		rsp_t      pending [$];
		int        errors;

		function new();
			ord_len = 9'd1;
			wrap = 1'b1;
			tempo = 5'd6;
			init_tempo = 5'd6;
			init_bpm = 8'd125;
			set_bpm(8'd125);
		endfunction

		function void set_bpm(bit [7:0] b);
			bpm = b;
			tick_len = TICK_NUMER / ((b == 0) ? 32'd1 : 32'(b));
		endfunction

		function void set_reg(cfg_idx_t idx, bit [8:0] v);
			case (idx)
				CFG_ORDER_LENGTH: ord_len = v;
				CFG_RESTART: restart = v[7:0];
				CFG_LOOP_PATTERN: loop_pat = v[0];
				CFG_INIT_TEMPO: init_tempo = v[4:0];
				CFG_INIT_BPM: init_bpm = v[7:0];
				default: ;
			endcase
		endfunction

		function bit [8:0] rows_of(bit [7:0] p);
			return (rows_tab[p] > MAX_ROWS) ? MAX_ROWS : rows_tab[p];
		endfunction

		function bit has_next();
			return int'(pos) < int'(ord_len) - 1;
		endfunction

		function bit next_row();
			bit done;
			done = 0;
			if (loop_jump) begin
				row = loop_row;
			end else if (brk) begin
				row = brk_row;
				pos = has_next() ? pos + 8'd1 : restart;
			end else if ({1'b0, row} + 9'd1 >= rows_of(pattern)) begin
				if (!loop_pat) begin
					if (has_next()) pos = pos + 8'd1;
					else if (wrap) pos = restart;
					else done = 1;
				end
				if (!done) row = 0;
			end else begin
				row = row + 8'd1;
			end
			loop_jump = 0;
			brk = 0;
			return done;
		endfunction

		function void apply_effect(bit [7:0] code, bit [7:0] param);
			if (code == FX_EXTENDED && param[7:4] == EXT_LOOP) begin
				if (param[3:0] == LOOP_SET) begin
					loop_row = row;
				end else begin
					if (loop_left > 0) begin
						loop_left--;
						if (loop_left == 0) loop_row = 0;
					end else begin
						loop_left = param[3:0];
					end
					if (loop_left > 0) loop_jump = 1;
				end
			end else if (code == FX_BREAK) begin
				brk = 1;
				brk_row = param[7:4] * 8'd10 + param[3:0];
			end else if (code == FX_SPEED) begin
				if (param < SPEED_SPLIT) tempo = (param == 0) ? 5'd1 : param[4:0];
				else set_bpm(param);
			end
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			bit [32:0] sum;
			e = '0;
			case (r.operation)
				OP_START: begin
					pos = r.position;
					row = r.start_row;
					pattern = order_tab[pos];
					wrap = r.song_loops;
					acc = 0;
					ticks = 0;
					fresh = 1;
					loop_row = 0;
					loop_left = 0;
					loop_jump = 0;
					brk = 0;
					brk_row = 0;
					tempo = (init_tempo == 0) ? 5'd1 : init_tempo;
					set_bpm(init_bpm);
					running = 1;
				end
				OP_EFFECT: if (running) begin
					if (r.first_cell) begin
						loop_jump = 0;
						brk = 0;
					end
					apply_effect(r.effect_code, r.fx_param);
				end
				OP_TIME: if (running) begin
					if (fresh) begin
						fresh = 0;
						e.row_started = 1;
						e.tick_started = 1;
					end
					sum = {1'b0, acc} + {1'b0, r.elapsed_ms, 16'h0};
					acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (acc >= tick_len) begin
						ticks = ticks + 5'd1;
						if (ticks >= tempo) begin
							ticks = 0;
							if (next_row()) begin
								running = 0;
								e.finished = 1;
								e.row_started = 0;
							end else begin
								pattern = order_tab[pos];
								e.row_started = 1;
							end
						end
						e.tick_started = 1;
						acc = acc - tick_len;
					end
				end
				OP_ORDER: order_tab[r.position] = r.table_value[7:0];
				OP_LENGTH: rows_tab[r.position] = r.table_value;
				default: ;
			endcase
			e.order_position = pos;
			e.current_row = row;
			e.current_pattern = pattern;
			e.is_playing = running;
			e.tempo_now = tempo;
			e.bpm_now = bpm;
			pending.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(rsp_t r);
			rsp_t e;
			if (pending.size() == 0) begin
				report("unrequested result", 32'(r.order_position), 32'd0);
			end else begin
				e = pending.pop_front();
				if (r.order_position !== e.order_position)
					report("order_position", 32'(r.order_position), 32'(e.order_position));
				if (r.current_row !== e.current_row)
					report("current_row", 32'(r.current_row), 32'(e.current_row));
				if (r.current_pattern !== e.current_pattern)
					report("current_pattern", 32'(r.current_pattern),
						32'(e.current_pattern));
				if (r.row_started !== e.row_started)
					report("row_started", 32'(r.row_started), 32'(e.row_started));
				if (r.tick_started !== e.tick_started)
					report("tick_started", 32'(r.tick_started), 32'(e.tick_started));
				if (r.finished !== e.finished)
					report("finished", 32'(r.finished), 32'(e.finished));
				if (r.is_playing !== e.is_playing)
					report("is_playing", 32'(r.is_playing), 32'(e.is_playing));
				if (r.tempo_now !== e.tempo_now)
					report("tempo_now", 32'(r.tempo_now), 32'(e.tempo_now));
				if (r.bpm_now !== e.bpm_now)
					report("bpm_now", 32'(r.bpm_now), 32'(e.bpm_now));
			end
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	trs_req_if req_ch ();
	trs_rsp_if rsp_ch ();
	trs_cfg_if cfg_ch ();
	song_scoreboard sb = new();
	int burst_left = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int rx_count = 0;
	int rx_mode = 0;

	tracker_row_order_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg(cfg_ch.sink)
	);

	always #5 clk = ~clk;

	initial begin
		req_ch.valid = 0;
		req_ch.data = '0;
		rsp_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = CFG_ORDER_LENGTH;
		cfg_ch.wdata = '0;
	end

	always @(negedge clk) begin
		rx_count <= rx_count + 1;
		if (rx_count % 64 == 0) rx_mode <= int'($urandom_range(0, 2));
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 0;
		end else begin
			case (rx_mode)
				0: rsp_ch.ready <= 1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= (rx_count % 5) > 1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tracker_row_order_sequencer_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task send_request(req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = int'($urandom_range(1, 12));
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid <= 0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
	endtask

	task write_reg(cfg_idx_t idx, bit [8:0] v);
		@(negedge clk);
		req_ch.valid <= 0;
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_ch.valid <= 0;
	endtask

	task drain();
		@(negedge clk);
		req_ch.valid <= 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function req_t mk(logic [2:0] op);
		req_t r;
		r = '0;
		r.operation = op;
		return r;
	endfunction

	function req_t rand_request();
		req_t r;
		int pick;
		r = '0;
		r.position = 8'($urandom_range(0, 255));
		r.start_row = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 6));
		r.song_loops = 1'($urandom_range(0, 1));
		r.first_cell = 1'($urandom_range(0, 1));
		r.table_value = 9'($urandom_range(0, 256));
		pick = int'($urandom_range(0, 99));
		if (pick < 6) begin
			r.operation = OP_START;
		end else if (pick < 40) begin
			r.operation = OP_EFFECT;
			r.fx_param = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 4))
				0: r.effect_code = FX_BREAK;
				1: begin
					r.effect_code = FX_EXTENDED;
					r.fx_param[7:4] = EXT_LOOP;
					if ($urandom_range(0, 1)) r.fx_param[3:0] = LOOP_SET;
				end
				2: r.effect_code = FX_SPEED;
				default: r.effect_code = 8'($urandom_range(0, 255));
			endcase
		end else if (pick < 92) begin
			r.operation = OP_TIME;
			case ($urandom_range(0, 9))
				0: r.elapsed_ms = 0;
				1: r.elapsed_ms = 16'hFFFF;
				2: r.elapsed_ms = 16'($urandom_range(0, 65535));
				default: r.elapsed_ms = 16'($urandom_range(0, 90));
			endcase
		end else if (pick < 95) begin
			r.operation = OP_ORDER;
			r.table_value = 9'($urandom_range(0, USED_PATTERNS - 1));
		end else if (pick < 98) begin
			r.operation = OP_LENGTH;
			if ($urandom_range(0, 2) != 0) r.table_value = 9'($urandom_range(0, 8));
		end else begin
			r.operation = 3'($urandom_range(5, 7));
		end
		return r;
	endfunction

	initial begin
		req_t r;
		logic [7:0] spd [4] = '{8'h00, 8'h1F, 8'h20, 8'hFF};
		repeat (11) @(negedge clk);
		arst_n <= 1;

		// fill the order table and the lengths of every pattern it names
		for (int i = 0; i < 256; i++) begin
			r = mk(OP_ORDER);
			r.position = 8'(i);
			r.table_value = 9'($urandom_range(0, USED_PATTERNS - 1));
			send_request(r);
		end
		for (int i = 0; i < USED_PATTERNS; i++) begin
			r = mk(OP_LENGTH);
			r.position = 8'(i);
			r.table_value = (i % 7 == 5) ? 9'd256
				: ((i % 5 == 3) ? 9'd0 : 9'($urandom_range(1, 8)));
			send_request(r);
		end

		// directed: idle items, extremes and every effect kind
		r = mk(OP_TIME);
		r.elapsed_ms = 16'hFFFF;
		send_request(r);
		r = mk(OP_EFFECT);
		r.effect_code = FX_SPEED;
		r.fx_param = 8'h03;
		send_request(r);
		r = mk(OP_START);
		r.position = 8'd255;
		r.start_row = 8'd255;
		send_request(r);
		for (int i = 0; i < 4; i++) begin
			r = mk(OP_EFFECT);
			r.effect_code = FX_SPEED;
			r.fx_param = spd[i];
			r.first_cell = i[0];
			send_request(r);
		end
		r = mk(OP_EFFECT);
		r.effect_code = FX_BREAK;
		r.fx_param = 8'h99;
		send_request(r);
		r = mk(OP_EFFECT);
		r.effect_code = FX_EXTENDED;
		r.fx_param = {EXT_LOOP, 4'hF};
		r.first_cell = 1;
		send_request(r);
		r.fx_param = {EXT_LOOP, LOOP_SET};
		r.first_cell = 0;
		send_request(r);
		r = mk(OP_TIME);
		r.elapsed_ms = 16'hFFFF;
		repeat (3) send_request(r);
		r.elapsed_ms = 0;
		send_request(r);
		send_request(mk(OP_SPARE_A));
		send_request(mk(OP_SPARE_B));
		send_request(mk(OP_SPARE_C));
		r = mk(OP_START);
		r.position = 8'd3;
		r.song_loops = 1;
		send_request(r);
		r = mk(OP_LENGTH);
		r.position = 8'd255;
		r.table_value = 9'd256;
		send_request(r);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: ;
				1: begin
					write_reg(CFG_ORDER_LENGTH, 9'd1);
					write_reg(CFG_RESTART, 9'd0);
					write_reg(CFG_LOOP_PATTERN, 9'd0);
					write_reg(CFG_INIT_TEMPO, 9'd1);
					write_reg(CFG_INIT_BPM, 9'd32);
				end
				2: begin
					write_reg(CFG_ORDER_LENGTH, 9'd256);
					write_reg(CFG_RESTART, 9'd255);
					write_reg(CFG_LOOP_PATTERN, 9'd1);
					write_reg(CFG_INIT_TEMPO, 9'd31);
					write_reg(CFG_INIT_BPM, 9'd255);
				end
				3: begin
					write_reg(CFG_ORDER_LENGTH, 9'd0);
					write_reg(CFG_LOOP_PATTERN, 9'd0);
					write_reg(CFG_INIT_TEMPO, 9'd0);
					write_reg(CFG_INIT_BPM, 9'd0);
				end
				default: begin
					write_reg(CFG_ORDER_LENGTH, 9'($urandom_range(1, 12)));
					write_reg(CFG_RESTART, 9'($urandom_range(0, 12)));
					write_reg(CFG_LOOP_PATTERN, 9'($urandom_range(0, 1)));
					write_reg(CFG_INIT_TEMPO, 9'($urandom_range(1, 4)));
					write_reg(CFG_INIT_BPM, 9'($urandom_range(32, 255)));
				end
			endcase
			r = mk(OP_START);
			r.position = 8'($urandom_range(0, 15));
			r.song_loops = 1'($urandom_range(0, 1));
			send_request(r);
			if (ph == 4) hold_left = 300;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) send_request(rand_request());
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tracker_row_order_sequencer_top: match");
		end else begin
			$display("tracker_row_order_sequencer_top: mismatch");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/trs_pkg.sv
rtl/trs_if.sv
rtl/trs_div.sv
rtl/trs_tables.sv
rtl/tracker_row_order_sequencer_top.sv
verif/tb_tracker_row_order_sequencer_top.sv
